@@ rtl/checksummed_command_framer_unit_assert.svh @@
// Assertion macros for the framer RTL.
`ifndef CHECKSUMMED_COMMAND_FRAMER_UNIT_ASSERT_SVH
`define CHECKSUMMED_COMMAND_FRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CMDF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("framer assertion failed");

// Next-cycle implication, checked outside reset.
`define CMDF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("framer assertion failed");

`endif

@@ rtl/cmdf_pkg.sv @@
// Types and constants of the checksummed command framer.
package cmdf_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hEB;
  localparam logic [7:0] SYNC_SECOND = 8'h90;
  localparam logic [7:0] CLOSE_BYTE  = 8'h16;
  localparam logic [15:0] LEN_BIAS   = 16'd2;

  // Action codes carried by an incoming request.
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_DATA,
    CMD_ERROR
  } cmd_kind_t;

  // One classified request handed from the front to the back.
  typedef struct packed {
    cmd_kind_t   kind;
    logic        close;
    logic [7:0]  ctl_code;
    logic [15:0] data_id;
    logic [15:0] len_field;
    logic [7:0]  data_byte;
  } cmd_t;

endpackage

@@ rtl/cmdf_if.sv @@
// Valid/ready channel interfaces for framer requests and frame bytes.
interface cmdf_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  ctl_code;
  logic [15:0] data_id;
  logic [15:0] payload_len;
  logic [7:0]  payload_byte;

  modport source (output valid, action, ctl_code, data_id, payload_len, payload_byte,
                  input ready);
  modport sink (input valid, action, ctl_code, data_id, payload_len, payload_byte,
                output ready);
endinterface

interface cmdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;
  logic       error;

  modport source (output valid, frame_byte, end_of_frame, error, input ready);
  modport sink (input valid, frame_byte, end_of_frame, error, output ready);
endinterface

@@ rtl/checksummed_command_framer_unit.sv @@
// Path: an accepted request passes the queue, the back-end request register and
// the output register. Throughput: one frame byte per cycle from the sequencer
// unless frame.ready stalls; a payload request emits one byte, a start request
// seven, one that closes the frame two more. QUEUE_DEPTH requests wait between.
// Reset: synchronous, clears the open-frame state, queue, checksum and output.
`include "checksummed_command_framer_unit_assert.svh"

module checksummed_command_framer_unit
  import cmdf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  cmdf_in_if.sink    cmd,
  cmdf_out_if.source frame
);

  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_data;

  // Front end classifies incoming requests.
  cmdf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue decouples the two halves.
  cmdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end emits the frame bytes.
  cmdf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .frame     (frame)
  );

  // An error result carries a zero byte and never closes a frame.
  `CMDF_ASSERT_NOW(a_err_clean, frame.valid && frame.error,
                   (frame.frame_byte == 8'h00) && !frame.end_of_frame)
  // The closing marker is always the close byte.
  `CMDF_ASSERT_NOW(a_eof_byte, frame.valid && frame.end_of_frame,
                   (frame.frame_byte == CLOSE_BYTE) && !frame.error)
  // Nothing leaves the block in the cycle after reset.
  `CMDF_ASSERT_NOW(a_reset_quiet, $past(rst), !frame.valid)

endmodule

@@ rtl/cmdf_front.sv @@
// Front end: accepts requests, tracks the open frame and classifies each request.
module cmdf_front
  import cmdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  cmdf_in_if.sink  cmd,
  output logic     push_valid,
  input  logic     push_ready,
  output cmd_t     push_data
);

  logic        frame_open;
  logic [15:0] bytes_left;
  logic        accept;

  assign cmd.ready  = push_ready;
  assign push_valid = cmd.valid;
  assign accept     = cmd.valid && push_ready;

  // Classify the request into a start, a payload byte or an error.
  always_comb begin
    push_data           = '0;
    push_data.ctl_code  = cmd.ctl_code;
    push_data.data_id   = cmd.data_id;
    push_data.len_field = cmd.payload_len + LEN_BIAS;
    push_data.data_byte = cmd.payload_byte;
    if (cmd.action == ACT_START) begin
      push_data.kind  = CMD_START;
      push_data.close = (cmd.payload_len == 16'd0);
    end else if (frame_open) begin
      push_data.kind  = CMD_DATA;
      push_data.close = (bytes_left == 16'd1);
    end else begin
      push_data.kind  = CMD_ERROR;
      push_data.close = 1'b0;
    end
  end

  // Frame tracking state.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      bytes_left <= '0;
    end else if (accept) begin
      if (cmd.action == ACT_START) begin
        frame_open <= (cmd.payload_len != 16'd0);
        bytes_left <= cmd.payload_len;
      end else if (frame_open) begin
        frame_open <= (bytes_left != 16'd1);
        bytes_left <= bytes_left - 16'd1;
      end
    end
  end

endmodule

@@ rtl/cmdf_queue.sv @@
// Short request queue between the front and the back.
module cmdf_queue
  import cmdf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/cmdf_back.sv @@
// Back end: sequences the frame bytes of each request and keeps the checksum.
module cmdf_back
  import cmdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  cmd_t       pop_data,
  cmdf_out_if.source frame
);

  typedef enum logic [3:0] {
    SLOT_SYNC1,
    SLOT_SYNC2,
    SLOT_CTL,
    SLOT_LEN_LO,
    SLOT_LEN_HI,
    SLOT_ID_LO,
    SLOT_ID_HI,
    SLOT_DATA,
    SLOT_SUM,
    SLOT_CLOSE,
    SLOT_ERR
  } slot_t;

  logic       busy;
  cmd_t       cur;
  logic [3:0] step;
  logic [7:0] sum;
  logic       ov;
  logic [7:0] obyte;
  logic       oeof;
  logic       oerr;

  slot_t      slot;
  logic [7:0] byte_now;
  logic [7:0] sum_next;
  logic       last;
  logic       emit;

  assign emit      = busy && (!ov || frame.ready);
  assign pop_ready = !busy || (emit && last);

  // Which byte of the request is emitted at the current step.
  always_comb begin
    unique case (cur.kind)
      CMD_START: begin
        unique case (step)
          4'd0:    slot = SLOT_SYNC1;
          4'd1:    slot = SLOT_SYNC2;
          4'd2:    slot = SLOT_CTL;
          4'd3:    slot = SLOT_LEN_LO;
          4'd4:    slot = SLOT_LEN_HI;
          4'd5:    slot = SLOT_ID_LO;
          4'd6:    slot = SLOT_ID_HI;
          4'd7:    slot = SLOT_SUM;
          default: slot = SLOT_CLOSE;
        endcase
      end
      CMD_DATA: begin
        unique case (step)
          4'd0:    slot = SLOT_DATA;
          4'd1:    slot = SLOT_SUM;
          default: slot = SLOT_CLOSE;
        endcase
      end
      default: slot = SLOT_ERR;
    endcase
  end

  // Byte value, checksum update and end of the request.
  always_comb begin
    unique case (slot)
      SLOT_SYNC1:  byte_now = SYNC_FIRST;
      SLOT_SYNC2:  byte_now = SYNC_SECOND;
      SLOT_CTL:    byte_now = cur.ctl_code;
      SLOT_LEN_LO: byte_now = cur.len_field[7:0];
      SLOT_LEN_HI: byte_now = cur.len_field[15:8];
      SLOT_ID_LO:  byte_now = cur.data_id[7:0];
      SLOT_ID_HI:  byte_now = cur.data_id[15:8];
      SLOT_DATA:   byte_now = cur.data_byte;
      SLOT_SUM:    byte_now = sum;
      SLOT_CLOSE:  byte_now = CLOSE_BYTE;
      default:     byte_now = 8'h00;
    endcase

    unique case (slot)
      SLOT_SYNC1:          sum_next = SYNC_FIRST;
      SLOT_SUM, SLOT_ERR:  sum_next = sum;
      SLOT_CLOSE:          sum_next = 8'h00;
      default:             sum_next = sum + byte_now;
    endcase

    last = (slot == SLOT_CLOSE) || (slot == SLOT_ERR) ||
           (!cur.close && ((slot == SLOT_ID_HI) || (slot == SLOT_DATA)));
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      sum  <= '0;
      ov   <= 1'b0;
    end else begin
      if (emit) begin
        ov    <= 1'b1;
        obyte <= byte_now;
        oeof  <= (slot == SLOT_CLOSE);
        oerr  <= (slot == SLOT_ERR);
        sum   <= sum_next;
      end else if (frame.ready) begin
        ov <= 1'b0;
      end
      if (pop_ready) begin
        busy <= pop_valid;
        if (pop_valid) begin
          cur <= pop_data;
        end
      end
      if (pop_ready && pop_valid) begin
        step <= '0;
      end else if (emit) begin
        step <= last ? '0 : step + 4'd1;
      end
    end
  end

  assign frame.valid        = ov;
  assign frame.frame_byte   = obyte;
  assign frame.end_of_frame = oeof;
  assign frame.error        = oerr;

endmodule

@@ test/tb_checksummed_command_framer_unit.sv @@
// Self-checking testbench for the checksummed command framer unit.
`timescale 1ns / 100ps

module tb_checksummed_command_framer_unit
  import cmdf_pkg::*;
();

  localparam int   TAIL_CYCLES = 20;
  localparam int   ITEMS_PER_PHASE = 115;

  typedef struct packed {
    logic        action;
    logic [7:0]  ctl_code;
    logic [15:0] data_id;
    logic [15:0] payload_len;
    logic [7:0]  payload_byte;
  } framer_req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
    logic       error;
  } frame_out_t;

  logic clk;
  logic rst;

  cmdf_in_if  cmd_bus ();
  cmdf_out_if frame_bus ();

  checksummed_command_framer_unit u_top (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_bus),
    .frame (frame_bus)
  );

  framer_req_t pending_reqs[$];
  frame_out_t  expected_bytes[$];
  int          n_queued;
  int          n_errors;
  int          send_idle_pct;
  int          recv_stall_pct;

  // Shadow of the framer state.
  logic        frm_open;
  logic [15:0] frm_left;
  logic [7:0]  frm_sum;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Append one expected frame byte.
  function automatic void emit_byte(logic [7:0] b, logic eof, logic err);
    frame_out_t e;
    e.frame_byte   = b;
    e.end_of_frame = eof;
    e.error        = err;
    expected_bytes = {expected_bytes, e};
  endfunction

  // A frame byte that also counts toward the checksum.
  function automatic void emit_summed(logic [7:0] b);
    frm_sum = frm_sum + b;
    emit_byte(b, 1'b0, 1'b0);
  endfunction

  // Checksum and closing byte, then the frame is closed.
  function automatic void emit_trailer();
    emit_byte(frm_sum, 1'b0, 1'b0);
    emit_byte(CLOSE_BYTE, 1'b1, 1'b0);
    frm_open = 1'b0;
    frm_left = '0;
    frm_sum  = '0;
  endfunction

  // Work out the frame bytes that one accepted request causes.
  function automatic void predict_frame(framer_req_t r);
    logic [15:0] len_field;
    if (r.action == ACT_START) begin
      len_field = r.payload_len + LEN_BIAS;
      frm_sum = '0;
      emit_summed(SYNC_FIRST);
      emit_summed(SYNC_SECOND);
      emit_summed(r.ctl_code);
      emit_summed(len_field[7:0]);
      emit_summed(len_field[15:8]);
      emit_summed(r.data_id[7:0]);
      emit_summed(r.data_id[15:8]);
      if (r.payload_len == '0) begin
        emit_trailer();
      end else begin
        frm_open = 1'b1;
        frm_left = r.payload_len;
      end
    end else if (!frm_open) begin
      emit_byte(8'h00, 1'b0, 1'b1);
    end else begin
      emit_summed(r.payload_byte);
      frm_left = frm_left - 16'd1;
      if (frm_left == '0) begin
        emit_trailer();
      end
    end
  endfunction

  // Queue one request with every field given.
  task automatic queue_req(logic act, logic [7:0] ctl, logic [15:0] id, logic [15:0] len,
                           logic [7:0] pb);
    framer_req_t r;
    r.action       = act;
    r.ctl_code     = ctl;
    r.data_id      = id;
    r.payload_len  = len;
    r.payload_byte = pb;
    pending_reqs = {pending_reqs, r};
    n_queued++;
  endtask

  // Start request with the given length, random control code and ID, and a random unused byte.
  task automatic queue_start(logic [15:0] len);
    queue_req(ACT_START, 8'($urandom), 16'($urandom), len, 8'($urandom));
  endtask

  // Payload request with random unused header fields.
  task automatic queue_payload(logic [7:0] b);
    queue_req(ACT_PAYLOAD, 8'($urandom), 16'($urandom), 16'($urandom), b);
  endtask

  // Mostly well-formed frames with random content, the rest noise.
  task automatic fill_random(int n_items);
    int target;
    int sel;
    int len;
    target = n_queued + n_items;
    while (n_queued < target) begin
      sel = $urandom_range(99);
      if (sel < 75) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        queue_start(16'(len));
        repeat (len) queue_payload(8'($urandom));
      end else if (sel < 85) begin
        repeat ($urandom_range(1, 3)) queue_payload(8'($urandom));
      end else if (sel < 95) begin
        len = $urandom_range(2, 10);
        queue_start(16'(len));
        repeat ($urandom_range(len - 1)) queue_payload(8'($urandom));
      end else begin
        queue_start(16'($urandom_range(65530, 65535)));
        repeat ($urandom_range(3)) queue_payload(8'($urandom));
      end
    end
  endtask

  // Request driver: holds each request until the block takes it.
  always @(posedge clk) begin
    if (rst) begin
      cmd_bus.valid        <= 1'b0;
      cmd_bus.action       <= ACT_START;
      cmd_bus.ctl_code     <= '0;
      cmd_bus.data_id      <= '0;
      cmd_bus.payload_len  <= '0;
      cmd_bus.payload_byte <= '0;
      frm_open = 1'b0;
      frm_left = '0;
      frm_sum  = '0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        predict_frame({cmd_bus.action, cmd_bus.ctl_code, cmd_bus.data_id,
                       cmd_bus.payload_len, cmd_bus.payload_byte});
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          {cmd_bus.action, cmd_bus.ctl_code, cmd_bus.data_id, cmd_bus.payload_len,
           cmd_bus.payload_byte} <= pending_reqs.pop_front();
          cmd_bus.valid <= 1'b1;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Frame byte monitor: compares each accepted byte with the oldest expectation.
  always @(posedge clk) begin
    frame_out_t want;
    if (rst) begin
      n_errors = 0;
    end else if (frame_bus.valid && frame_bus.ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected frame byte %02h eof %0b err %0b", $time,
                 frame_bus.frame_byte, frame_bus.end_of_frame, frame_bus.error);
        n_errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (frame_bus.frame_byte !== want.frame_byte) begin
          $display("%0t: frame_byte expected %02h, actual %02h", $time,
                   want.frame_byte, frame_bus.frame_byte);
          n_errors++;
        end
        if (frame_bus.end_of_frame !== want.end_of_frame) begin
          $display("%0t: end_of_frame expected %0b, actual %0b", $time,
                   want.end_of_frame, frame_bus.end_of_frame);
          n_errors++;
        end
        if (frame_bus.error !== want.error) begin
          $display("%0t: error expected %0b, actual %0b", $time,
                   want.error, frame_bus.error);
          n_errors++;
        end
      end
    end
    frame_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Overall time limit.
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

  // Main sequence: reset, directed requests, then random phases.
  initial begin
    n_queued       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst            = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Stray payload right after reset.
    queue_req(ACT_PAYLOAD, 8'h00, 16'h0000, 16'h0000, 8'hFF);
    // Empty frames with all-ones and all-zeros headers.
    queue_req(ACT_START, 8'hFF, 16'hFFFF, 16'h0000, 8'hFF);
    queue_req(ACT_START, 8'h00, 16'h0000, 16'h0000, 8'h00);
    // Longest legal length, abandoned by a new start.
    queue_req(ACT_START, 8'hA5, 16'h5A5A, 16'd65533, 8'h00);
    queue_payload(8'hFF);
    queue_payload(8'h00);
    queue_req(ACT_START, 8'h3C, 16'h1234, 16'd1, 8'hC3);
    queue_payload(8'h80);
    // Payload after the frame has closed.
    queue_payload(8'h7F);
    // Lengths whose field wraps around.
    queue_req(ACT_START, 8'h01, 16'h8000, 16'hFFFF, 8'hAA);
    queue_payload(8'h55);
    queue_req(ACT_START, 8'h80, 16'h0001, 16'hFFFE, 8'h55);
    // Short complete frames.
    queue_req(ACT_START, 8'h7E, 16'h00FF, 16'd2, 8'h00);
    queue_payload(8'h00);
    queue_payload(8'hFF);
    queue_start(16'd3);
    queue_payload(8'h01);
    queue_payload(8'h02);
    queue_payload(8'h03);
    // Open frame cut short by an empty frame.
    queue_start(16'd4);
    queue_payload(8'h10);
    queue_start(16'd0);

    fill_random(ITEMS_PER_PHASE - n_queued);
    while (pending_reqs.size() > 0) @(negedge clk);

    send_idle_pct = 88;
    fill_random(ITEMS_PER_PHASE);
    while (pending_reqs.size() > 0) @(negedge clk);

    send_idle_pct  = 0;
    recv_stall_pct = 88;
    fill_random(ITEMS_PER_PHASE);
    while (pending_reqs.size() > 0) @(negedge clk);

    send_idle_pct  = 31;
    recv_stall_pct = 31;
    fill_random(ITEMS_PER_PHASE);

    // Drain, then let the pipeline settle.
    while (pending_reqs.size() > 0 || cmd_bus.valid || expected_bytes.size() > 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/cmdf_pkg.sv
rtl/cmdf_if.sv
rtl/cmdf_front.sv
rtl/cmdf_queue.sv
rtl/cmdf_back.sv
rtl/checksummed_command_framer_unit.sv
test/tb_checksummed_command_framer_unit.sv
